// ----- rtl/i2c_reg_pkg.sv -----
`default_nettype none

package i2c_reg_pkg;

  // func codes carried in s_tuser
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  // register select, paddr[2]
  localparam logic REG_DEVICE = 1'b0;
  localparam logic REG_RETRY  = 1'b1;

  localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd160;
  localparam logic [3:0] RETRY_LIMIT_RESET    = 4'd10;

  typedef struct packed {
    logic       status;
    logic       done_res;
    logic       busy_res;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       sda_oe;
    logic       sda_out;
    logic       scl;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/i2c_reg_buf.sv -----
`default_nettype none

module i2c_reg_buf #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/i2c_reg_seq.sv -----
`default_nettype none

module i2c_reg_seq #(
  parameter int MAX_BYTES = 32,
  parameter int AW        = 5,
  parameter int FW        = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_en,
  input  wire logic [1:0]           func,
  input  wire logic                 sda_in,
  input  wire logic [7:0]           reg_addr,
  input  wire logic [5:0]           byte_count,
  input  wire logic [7:0]           data_byte,
  input  wire logic [7:0]           device_address,
  input  wire logic [3:0]           retry_limit,
  input  wire logic [7:0]           buf_rdata,
  output logic                      buf_we,
  output logic      [AW-1:0]        buf_waddr,
  output logic      [7:0]           buf_wdata,
  output logic      [AW-1:0]        buf_raddr,
  output i2c_reg_pkg::res_t         res
);

  import i2c_reg_pkg::*;

  typedef enum logic [5:0] {
    SEG_IDLE  = 6'b000001,
    SEG_START = 6'b000010,
    SEG_SEND  = 6'b000100,
    SEG_RECV  = 6'b001000,
    SEG_ACK   = 6'b010000,
    SEG_STOP  = 6'b100000
  } seg_t;

  typedef enum logic [8:0] {
    ST_ASTART = 9'b000000001,
    ST_DEV    = 9'b000000010,
    ST_REG    = 9'b000000100,
    ST_DATA   = 9'b000001000,
    ST_RSTART = 9'b000010000,
    ST_RDEV   = 9'b000100000,
    ST_RECV   = 9'b001000000,
    ST_ACK    = 9'b010000000,
    ST_STOP   = 9'b100000000
  } stage_t;

  localparam logic [8:0]    MAXB  = 9'(MAX_BYTES);
  localparam logic [FW-1:0] MAXF  = FW'(MAX_BYTES);

  seg_t          seg, seg_next;
  stage_t        stage, stage_next;
  logic [2:0]    phase, phase_next;
  logic [2:0]    bit_index, bit_index_next;
  logic [5:0]    byte_index, byte_index_next;
  logic [3:0]    retry_count, retry_count_next;
  logic [7:0]    shift_reg, shift_reg_next;
  logic          ack_seen, ack_seen_next;
  logic          is_read, is_read_next;
  logic [7:0]    target_reg, target_reg_next;
  logic [5:0]    count_total, count_total_next;
  logic [FW-1:0] fill, fill_next;
  logic          line_scl, line_scl_next;
  logic          line_sda, line_sda_next;
  logic          line_oe, line_oe_next;
  logic          busy, busy_next;
  logic          status_q, status_q_next;

  logic          seg_end;
  logic          rx_valid;
  logic [7:0]    rx_byte;
  logic          done;
  logic [5:0]    cnt_clamp;

  always_comb begin
    cnt_clamp = ({3'b000, byte_count} > MAXB) ? MAXB[5:0] : byte_count;
  end

  assign buf_raddr = AW'(byte_index);
  assign buf_waddr = AW'(fill);
  assign buf_wdata = data_byte;

  always_comb begin
    seg_next         = seg;
    stage_next       = stage;
    phase_next       = phase;
    bit_index_next   = bit_index;
    byte_index_next  = byte_index;
    retry_count_next = retry_count;
    shift_reg_next   = shift_reg;
    ack_seen_next    = ack_seen;
    is_read_next     = is_read;
    target_reg_next  = target_reg;
    count_total_next = count_total;
    fill_next        = fill;
    line_scl_next    = line_scl;
    line_sda_next    = line_sda;
    line_oe_next     = line_oe;
    busy_next        = busy;
    status_q_next    = status_q;
    seg_end          = 1'b0;
    rx_valid         = 1'b0;
    rx_byte          = 8'h00;
    done             = 1'b0;
    buf_we           = 1'b0;

    if (item_en) begin
      if (func == FUNC_TICK) begin
        if (busy) begin
          // one bus phase
          case (seg)
            SEG_START: begin
              case (phase)
                3'd0: begin
                  line_oe_next  = 1'b1;
                  line_sda_next = 1'b1;
                end
                3'd1: line_scl_next = 1'b1;
                3'd2: line_sda_next = 1'b0;
                default: begin
                  line_scl_next = 1'b0;
                  seg_end       = 1'b1;
                end
              endcase
              phase_next = phase + 3'd1;
            end
            SEG_SEND: begin
              case (phase)
                3'd0: begin
                  line_oe_next  = 1'b1;
                  line_scl_next = 1'b0;
                  line_sda_next = shift_reg[~bit_index];
                  phase_next    = 3'd1;
                end
                3'd1: begin
                  line_scl_next = 1'b1;
                  if (bit_index == 3'd7) begin
                    bit_index_next = 3'd0;
                    phase_next     = 3'd2;
                  end else begin
                    bit_index_next = bit_index + 3'd1;
                    phase_next     = 3'd0;
                  end
                end
                3'd2: begin
                  line_scl_next = 1'b0;
                  phase_next    = 3'd3;
                end
                3'd3: begin
                  line_oe_next = 1'b0;
                  phase_next   = 3'd4;
                end
                3'd4: begin
                  line_scl_next = 1'b1;
                  ack_seen_next = ~sda_in;
                  phase_next    = 3'd5;
                end
                default: begin
                  line_scl_next = 1'b0;
                  seg_end       = 1'b1;
                end
              endcase
            end
            SEG_RECV: begin
              line_oe_next = 1'b0;
              case (phase)
                3'd0: phase_next = 3'd1;
                3'd1: begin
                  line_scl_next = 1'b0;
                  phase_next    = 3'd2;
                end
                3'd2: begin
                  line_scl_next  = 1'b1;
                  shift_reg_next = {shift_reg[6:0], sda_in};
                  phase_next     = 3'd3;
                end
                3'd3: begin
                  if (bit_index == 3'd7) begin
                    bit_index_next = 3'd0;
                    phase_next     = 3'd4;
                  end else begin
                    bit_index_next = bit_index + 3'd1;
                    phase_next     = 3'd0;
                  end
                end
                default: begin
                  line_scl_next = 1'b0;
                  rx_valid      = 1'b1;
                  rx_byte       = shift_reg;
                  seg_end       = 1'b1;
                end
              endcase
            end
            SEG_ACK: begin
              case (phase)
                3'd0: begin
                  line_oe_next  = 1'b1;
                  line_sda_next = (byte_index >= count_total);  // NACK after last byte
                end
                3'd1: line_scl_next = 1'b1;
                default: begin
                  line_scl_next = 1'b0;
                  seg_end       = 1'b1;
                end
              endcase
              phase_next = phase + 3'd1;
            end
            SEG_STOP: begin
              case (phase)
                3'd0: begin
                  line_oe_next  = 1'b1;
                  line_sda_next = 1'b0;
                end
                3'd1: line_scl_next = 1'b1;
                default: begin
                  line_sda_next = 1'b1;
                  seg_end       = 1'b1;
                end
              endcase
              phase_next = phase + 3'd1;
            end
            default: ;
          endcase

          // pick the next segment
          if (seg_end) begin
            phase_next     = 3'd0;
            bit_index_next = 3'd0;
            case (stage)
              ST_ASTART: begin
                shift_reg_next = device_address;
                stage_next     = ST_DEV;
                seg_next       = SEG_SEND;
              end
              ST_DEV: begin
                if (!is_read && !ack_seen && (retry_count < retry_limit)) begin
                  retry_count_next = retry_count + 4'd1;
                  stage_next       = ST_ASTART;
                  seg_next         = SEG_START;
                end else begin
                  shift_reg_next = target_reg;
                  stage_next     = ST_REG;
                  seg_next       = SEG_SEND;
                end
              end
              ST_REG, ST_DATA: begin
                if (is_read && (stage == ST_REG)) begin
                  seg_next = SEG_START;
                  if (!ack_seen && (retry_count < retry_limit)) begin
                    retry_count_next = retry_count + 4'd1;
                    stage_next       = ST_ASTART;
                  end else begin
                    stage_next = ST_RSTART;
                  end
                end else if (!ack_seen) begin
                  status_q_next = 1'b1;
                  done          = 1'b1;
                  busy_next     = 1'b0;
                  seg_next      = SEG_IDLE;
                end else if (byte_index < count_total) begin
                  // buffer read of byte_index was registered cycles ago
                  shift_reg_next  = buf_rdata;
                  byte_index_next = byte_index + 6'd1;
                  stage_next      = ST_DATA;
                  seg_next        = SEG_SEND;
                end else begin
                  stage_next = ST_STOP;
                  seg_next   = SEG_STOP;
                end
              end
              ST_RSTART: begin
                shift_reg_next = device_address + 8'd1;
                stage_next     = ST_RDEV;
                seg_next       = SEG_SEND;
              end
              ST_RDEV: begin
                if (!ack_seen) begin
                  status_q_next = 1'b1;
                  done          = 1'b1;
                  busy_next     = 1'b0;
                  seg_next      = SEG_IDLE;
                end else begin
                  stage_next = ST_RECV;
                  seg_next   = SEG_RECV;
                end
              end
              ST_RECV: begin
                byte_index_next = byte_index + 6'd1;
                stage_next      = ST_ACK;
                seg_next        = SEG_ACK;
              end
              ST_ACK: begin
                if (byte_index >= count_total) begin
                  stage_next = ST_STOP;
                  seg_next   = SEG_STOP;
                end else begin
                  stage_next = ST_RECV;
                  seg_next   = SEG_RECV;
                end
              end
              default: begin
                status_q_next = 1'b0;
                done          = 1'b1;
                busy_next     = 1'b0;
                seg_next      = SEG_IDLE;
              end
            endcase
          end
        end
      end else if (!busy) begin
        if (func == FUNC_LOAD) begin
          if (fill < MAXF) begin
            buf_we    = 1'b1;
            fill_next = fill + FW'(1);
          end
        end else begin
          is_read_next     = (func == FUNC_READ);
          target_reg_next  = reg_addr;
          count_total_next = cnt_clamp;
          if ((func == FUNC_READ) && (cnt_clamp == 6'd0)) begin
            count_total_next = 6'd1;
          end
          if (func != FUNC_READ) begin
            fill_next = '0;
          end
          byte_index_next  = 6'd0;
          retry_count_next = 4'd0;
          busy_next        = 1'b1;
          stage_next       = ST_ASTART;
          seg_next         = SEG_START;
          phase_next       = 3'd0;
          bit_index_next   = 3'd0;
        end
      end
    end
  end

  always_comb begin
    res.scl      = line_scl_next;
    res.sda_out  = line_sda_next;
    res.sda_oe   = line_oe_next;
    res.rx_byte  = rx_byte;
    res.rx_valid = rx_valid;
    res.busy_res = busy_next;
    res.done_res = done;
    res.status   = status_q_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg         <= SEG_IDLE;
      stage       <= ST_ASTART;
      phase       <= 3'd0;
      bit_index   <= 3'd0;
      byte_index  <= 6'd0;
      retry_count <= 4'd0;
      shift_reg   <= 8'h00;
      ack_seen    <= 1'b0;
      is_read     <= 1'b0;
      target_reg  <= 8'h00;
      count_total <= 6'd0;
      fill        <= '0;
      line_scl    <= 1'b1;
      line_sda    <= 1'b1;
      line_oe     <= 1'b1;
      busy        <= 1'b0;
      status_q    <= 1'b0;
    end else begin
      seg         <= seg_next;
      stage       <= stage_next;
      phase       <= phase_next;
      bit_index   <= bit_index_next;
      byte_index  <= byte_index_next;
      retry_count <= retry_count_next;
      shift_reg   <= shift_reg_next;
      ack_seen    <= ack_seen_next;
      is_read     <= is_read_next;
      target_reg  <= target_reg_next;
      count_total <= count_total_next;
      fill        <= fill_next;
      line_scl    <= line_scl_next;
      line_sda    <= line_sda_next;
      line_oe     <= line_oe_next;
      busy        <= busy_next;
      status_q    <= status_q_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/i2c_register_master.sv -----
// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       tuser: func; tdata: sda_in, reg_addr, byte_count,
//                                          data_byte
// m_*       out  m_tvalid / m_tready       tdata: scl, sda_out, sda_oe, rx_byte, rx_valid,
//                                          busy_res, done_res, status
// apb       in   psel / penable / pready   device_address @0x0, retry_limit @0x4
//
// One beat in, one beat out. Each beat is handled combinationally by the phase
// sequencer and lands in the output register, so a beat can be taken every clock unless the output stalls.
// s_tready drops only while the output register is full and m_tready is low.
// The write buffer has a registered read port, prefetched from the byte index.
// rst is synchronous: bus lines idle high, transfer idle, registers at defaults.
`default_nettype none

module i2c_register_master #(
  parameter int MAX_BYTES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // sda_in, reg_addr, byte_count, data_byte, pad
  input  wire logic [1:0]  s_tuser,   // func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata,   // scl, sda_out, sda_oe, rx_byte, rx_valid,
                                      // busy_res, done_res, status, pad
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  import i2c_reg_pkg::*;

  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int FW = $clog2(MAX_BYTES + 1);

  logic [7:0]    device_address;
  logic [3:0]    retry_limit;
  logic          accept;
  logic          buf_we;
  logic [AW-1:0] buf_waddr;
  logic [7:0]    buf_wdata;
  logic [AW-1:0] buf_raddr;
  logic [7:0]    buf_rdata;
  res_t          res;

  // config registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEVICE_ADDRESS_RESET;
      retry_limit    <= RETRY_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_DEVICE: device_address <= pwdata[7:0];
        REG_RETRY:  retry_limit    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DEVICE: prdata = {24'h000000, device_address};
      REG_RETRY:  prdata = {28'h0000000, retry_limit};
      default:    prdata = 32'h00000000;
    endcase
  end

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  i2c_reg_buf #(
    .DEPTH (MAX_BYTES),
    .AW    (AW)
  ) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  i2c_reg_seq #(
    .MAX_BYTES (MAX_BYTES),
    .AW        (AW),
    .FW        (FW)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .item_en        (accept),
    .func           (s_tuser),
    .sda_in         (s_tdata[0]),
    .reg_addr       (s_tdata[8:1]),
    .byte_count     (s_tdata[14:9]),
    .data_byte      (s_tdata[22:15]),
    .device_address (device_address),
    .retry_limit    (retry_limit),
    .buf_rdata      (buf_rdata),
    .buf_we         (buf_we),
    .buf_waddr      (buf_waddr),
    .buf_wdata      (buf_wdata),
    .buf_raddr      (buf_raddr),
    .res            (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {1'b0, res.status, res.done_res, res.busy_res, res.rx_valid,
                  res.rx_byte, res.sda_oe, res.sda_out, res.scl};
    end
  end

`ifndef SYNTH
  a_out_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted beat produced no result");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[13]) |-> !m_tdata[12])
    else $error("done reported while still busy");

  a_rx_while_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[11]) |-> (m_tdata[12] && !m_tdata[13]))
    else $error("received byte outside a transfer");

  a_rx_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[11]) |-> (m_tdata[10:3] == 8'h00))
    else $error("rx_byte nonzero without rx_valid");
`endif

endmodule

`default_nettype wire
